// ----- rtl/spw_pkg.sv -----
// ----------------------------------------------------------------------------
// spw_pkg: shared constants, types and helpers
// Widths, register indexes, reset values, stage offsets and the capped
// fixed-point helpers used by the water pair force pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spw_pkg;

  // histogram depth
  localparam int RDF_BINS = 512;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_COULOMB  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPS4     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_SQ = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OX_Q     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HY_Q     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS     = 3'd5;

  localparam logic [31:0]        RST_COULOMB  = 32'd65536;
  localparam logic [31:0]        RST_EPS4     = 32'd40737;
  localparam logic [31:0]        RST_SIGMA_SQ = 32'd168118442;
  localparam logic signed [15:0] RST_OX_Q     = -16'sd13435;
  localparam logic signed [15:0] RST_HY_Q     = 16'sd6718;
  localparam logic [7:0]         RST_BINS     = 8'd20;
  localparam logic [15:0]        RST_BINS_SQ  = 16'd400;

  // field widths
  localparam int DIST_W = 32;
  localparam int OUT_W  = 48;
  localparam int BIN_W  = 9;
  localparam int DATA_OUT_W = 160;

  // arithmetic widths
  localparam int MAG_W     = 59;
  localparam int SUM_W     = 61;
  localparam int MUL_W     = 64;
  localparam int PROD_W    = 128;
  localparam int SQ_IN_W   = 56;
  localparam int ROOT_W    = 28;
  localparam int SQ_STAGES = 28;
  localparam int DEN_W     = 32;
  localparam int QUO_W     = 57;
  localparam int DIV_STAGES = 57;
  localparam int T_W       = 51;
  localparam int CM_W      = 63;

  // delay line lengths and taps
  localparam int T_DLY      = 83;
  localparam int INV_DLY    = 31;
  localparam int INV_LJ_TAP = 15;
  localparam int INV_CD_TAP = 30;
  localparam int X_DLY      = 3;
  localparam int EM_DLY     = 3;
  localparam int LJE_DLY    = 18;
  localparam int LJD_DLY    = 15;
  localparam int SG_DLY     = 10;
  localparam int SG_LJE_TAP = 6;
  localparam int SG_LJD_TAP = 9;
  localparam int SIDE_DLY   = 89;
  localparam int BIN_DLY    = 62;
  localparam int V_LEN      = 93;

  typedef logic [MAG_W-1:0]        mag_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  localparam mag_t CAP_MAG = mag_t'(59'd1 << 58);
  localparam sum_t SAT_HI  = (61'sd1 <<< 47) - 61'sd1;
  localparam sum_t SAT_LO  = -(61'sd1 <<< 47);

  localparam logic [BIN_W-1:0] RDF_LAST = BIN_W'(RDF_BINS - 1);

  typedef struct packed {
    logic zero;
    logic oo;
    logic qneg;
    logic tnz;
  } side_t;

  typedef struct packed {
    logic             ge;
    logic [BIN_W-1:0] bin;
  } bin_t;

  typedef struct packed {
    logic neg;
    mag_t mag;
  } smag_t;

  typedef struct packed {
    logic [OUT_W-1:0] force_over_r;
    logic [OUT_W-1:0] energy_inc;
    logic [OUT_W-1:0] coulomb_inc;
    logic [BIN_W-1:0] rdf_bin;
    logic             rdf_hit;
    logic             range_error;
  } res_t;

  // shift right with truncation, cap magnitude
  function automatic mag_t cap_shr(input logic [PROD_W-1:0] p, input int unsigned sh);
    logic [PROD_W-1:0] q;
    q = p >> sh;
    if (q > {{(PROD_W-MAG_W){1'b0}}, CAP_MAG}) return CAP_MAG;
    return q[MAG_W-1:0];
  endfunction

  function automatic sum_t sgn_mag(input mag_t m, input logic neg);
    sum_t v;
    v = $signed({2'b00, m});
    return neg ? -v : v;
  endfunction

  function automatic logic [OUT_W-1:0] sat48(input sum_t v);
    if (v > SAT_HI) return SAT_HI[OUT_W-1:0];
    if (v < SAT_LO) return SAT_LO[OUT_W-1:0];
    return v[OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/spc_water_pair_force.sv -----
// ----------------------------------------------------------------------------
// spc_water_pair_force: water pair force and energy pipeline
// Coulomb and oxygen Lennard-Jones terms plus radial distribution bin,
// fixed point, one pair per cycle while the skid word is empty.
// ----------------------------------------------------------------------------
// throughput: one word per cycle while the skid word is empty; the 57 stage divider after
//   the 28 stage square root sets the depth, every unit is fully pipelined
// a two-entry output buffer lets the pipe run while a result waits
// reset: synchronous, clears all valid bits and loads the register defaults
`timescale 1ns / 1ps
`default_nettype none

module spc_water_pair_force (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [31:0]                      in_tdata,   // dist_sq
  input  logic [1:0]                       in_tuser,   // first_kind, second_kind
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // force_over_r, energy_inc, coulomb_inc, rdf_bin, zero fill
  output logic [spw_pkg::DATA_OUT_W-1:0]   out_tdata,
  output logic [1:0]                       out_tuser,  // rdf_hit, range_error
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [spw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spw_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import spw_pkg::*;

  // configuration
  logic [31:0]        coulomb_r, eps4_r, sigma_sq_r;
  logic signed [15:0] ox_q_r, hy_q_r;
  logic [7:0]         bins_r;
  logic [15:0]        bins_sq_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coulomb_r  <= RST_COULOMB;
      eps4_r     <= RST_EPS4;
      sigma_sq_r <= RST_SIGMA_SQ;
      ox_q_r     <= RST_OX_Q;
      hy_q_r     <= RST_HY_Q;
      bins_r     <= RST_BINS;
      bins_sq_r  <= RST_BINS_SQ;
    end else begin
      bins_sq_r <= 16'(bins_r) * 16'(bins_r);
      if (cfg_valid) begin
        case (cfg_index)
          CFG_COULOMB:  coulomb_r  <= cfg_data;
          CFG_EPS4:     eps4_r     <= cfg_data;
          CFG_SIGMA_SQ: sigma_sq_r <= cfg_data;
          CFG_OX_Q:     ox_q_r     <= $signed(cfg_data[15:0]);
          CFG_HY_Q:     hy_q_r     <= $signed(cfg_data[15:0]);
          CFG_BINS:     bins_r     <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  // pipeline control
  logic             en;
  logic [V_LEN-1:0] v_r;
  logic             out_v_r, skid_v_r;

  assign en        = !skid_v_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[V_LEN-2:0], in_tvalid};
    end
  end

  // front stages
  logic [DIST_W-1:0]  d0_r;
  logic               k1_0_r, k2_0_r;
  logic               zero1_r, oo1_r, qneg1_r;
  logic [30:0]        qmag1_r;
  logic [47:0]        rb1_r;
  logic               zero2_r, oo2_r, qneg2_r;
  logic [T_W-1:0]     t2_r;
  logic signed [15:0] qa, qb;
  logic signed [31:0] qq;
  logic [62:0]        tprod;

  assign qa    = k1_0_r ? hy_q_r : ox_q_r;
  assign qb    = k2_0_r ? hy_q_r : ox_q_r;
  assign qq    = qa * qb;
  assign tprod = 63'(qmag1_r) * 63'(coulomb_r);

  always_ff @(posedge clk) begin
    if (en) begin
      d0_r    <= in_tdata;
      k1_0_r  <= in_tuser[0];
      k2_0_r  <= in_tuser[1];
      zero1_r <= (d0_r == '0);
      oo1_r   <= !k1_0_r && !k2_0_r;
      qneg1_r <= qq[31];
      qmag1_r <= qq[31] ? 31'(-qq) : qq[30:0];
      rb1_r   <= 48'(bins_sq_r) * 48'(d0_r);
      zero2_r <= zero1_r;
      oo2_r   <= oo1_r;
      qneg2_r <= qneg1_r;
      t2_r    <= tprod[62:12];
    end
  end

  // square roots and reciprocals
  logic [ROOT_W-1:0] rq, root_b;
  logic [QUO_W-1:0]  inv, ir;

  spw_isqrt u_sqrt_r (
    .clk  (clk),
    .en   (en),
    .v    ({d0_r, 24'd0}),
    .root (rq)
  );

  spw_isqrt u_sqrt_bin (
    .clk  (clk),
    .en   (en),
    .v    ({8'd0, rb1_r}),
    .root (root_b)
  );

  spw_div u_div_inv (
    .clk (clk),
    .en  (en),
    .den (d0_r),
    .quo (inv)
  );

  spw_div u_div_ir (
    .clk (clk),
    .en  (en),
    .den ({{(DEN_W-ROOT_W){1'b0}}, rq}),
    .quo (ir)
  );

  // delay lines
  side_t          side_d_r [SIDE_DLY];
  bin_t           bin_d_r  [BIN_DLY];
  logic [T_W-1:0] t_d_r    [T_DLY];
  logic [QUO_W-1:0] inv_d_r [INV_DLY];
  mag_t           x_d_r    [X_DLY];
  mag_t           em_d_r   [EM_DLY];
  smag_t          lje_d_r  [LJE_DLY];
  smag_t          ljd_d_r  [LJD_DLY];
  logic [1:0]     sg_d_r   [SG_DLY];

  side_t          side_in;
  bin_t           bin_in;
  logic [15:0]    binv;

  assign side_in.zero = zero2_r;
  assign side_in.oo   = oo2_r;
  assign side_in.qneg = qneg2_r;
  assign side_in.tnz  = (t2_r != '0);

  assign binv       = root_b[ROOT_W-1:12];
  assign bin_in.ge  = binv >= 16'(RDF_BINS);
  assign bin_in.bin = bin_in.ge ? RDF_LAST : binv[BIN_W-1:0];

  // multiply chain
  logic [PROD_W-1:0] em_p, cd_p, x_p, xx_p, a_p, ab_p, ac_p, lje_p, ljf_p, ljd_p;
  mag_t              em_r, cd_r, x_r, xx_r, a_r, a2_r, bm_r, ab_r, ac_r;
  mag_t              lje_r, ljf_r, ljd_r;
  logic [CM_W-1:0]   cm_r;
  logic [CM_W-1:0]   a12;
  logic              bneg, cneg;

  assign a12  = {a_r, 3'b000} + {1'b0, a_r, 2'b00};
  assign bneg = a_r < mag_t'(64'h1_0000_0000);
  assign cneg = a_r > mag_t'(64'h8000_0000);

  spw_mul u_mul_em (.clk(clk), .en(en), .a(64'(t_d_r[T_DLY-1])), .b(64'(ir)), .p(em_p));
  spw_mul u_mul_cd (.clk(clk), .en(en), .a(64'(em_r)), .b(64'(inv_d_r[INV_CD_TAP])),
                    .p(cd_p));
  spw_mul u_mul_x  (.clk(clk), .en(en), .a(64'(sigma_sq_r)), .b(64'(inv)), .p(x_p));
  spw_mul u_mul_xx (.clk(clk), .en(en), .a(64'(x_r)), .b(64'(x_r)), .p(xx_p));
  spw_mul u_mul_a  (.clk(clk), .en(en), .a(64'(xx_r)), .b(64'(x_d_r[X_DLY-1])), .p(a_p));
  spw_mul u_mul_ab (.clk(clk), .en(en), .a(64'(a2_r)), .b(64'(bm_r)), .p(ab_p));
  spw_mul u_mul_ac (.clk(clk), .en(en), .a(64'(a2_r)), .b(64'(cm_r)), .p(ac_p));
  spw_mul u_mul_lje (.clk(clk), .en(en), .a(64'(ab_r)), .b(64'(eps4_r)), .p(lje_p));
  spw_mul u_mul_ljf (.clk(clk), .en(en), .a(64'(ac_r)), .b(64'(eps4_r)), .p(ljf_p));
  spw_mul u_mul_ljd (.clk(clk), .en(en), .a(64'(ljf_r)), .b(64'(inv_d_r[INV_LJ_TAP])),
                     .p(ljd_p));

  always_ff @(posedge clk) begin
    if (en) begin
      em_r  <= cap_shr(em_p, 32);
      cd_r  <= cap_shr(cd_p, 32);
      x_r   <= cap_shr(x_p, 24);
      xx_r  <= cap_shr(xx_p, 32);
      a_r   <= cap_shr(a_p, 32);
      a2_r  <= a_r;
      // |a - 1.0| and |6 - 12a| in Q.32
      bm_r  <= bneg ? mag_t'(64'h1_0000_0000) - a_r : a_r - mag_t'(64'h1_0000_0000);
      cm_r  <= cneg ? a12 - CM_W'(64'h6_0000_0000) : CM_W'(64'h6_0000_0000) - a12;
      ab_r  <= cap_shr(ab_p, 32);
      ac_r  <= cap_shr(ac_p, 32);
      lje_r <= cap_shr(lje_p, 16);
      ljf_r <= cap_shr(ljf_p, 16);
      ljd_r <= cap_shr(ljd_p, 32);

      side_d_r[0] <= side_in;
      for (int k = 1; k < SIDE_DLY; k++) side_d_r[k] <= side_d_r[k-1];
      bin_d_r[0] <= bin_in;
      for (int k = 1; k < BIN_DLY; k++) bin_d_r[k] <= bin_d_r[k-1];
      t_d_r[0] <= t2_r;
      for (int k = 1; k < T_DLY; k++) t_d_r[k] <= t_d_r[k-1];
      inv_d_r[0] <= inv;
      for (int k = 1; k < INV_DLY; k++) inv_d_r[k] <= inv_d_r[k-1];
      x_d_r[0] <= x_r;
      for (int k = 1; k < X_DLY; k++) x_d_r[k] <= x_d_r[k-1];
      em_d_r[0] <= em_r;
      for (int k = 1; k < EM_DLY; k++) em_d_r[k] <= em_d_r[k-1];
      sg_d_r[0] <= {bneg, cneg};
      for (int k = 1; k < SG_DLY; k++) sg_d_r[k] <= sg_d_r[k-1];
      lje_d_r[0] <= '{neg: sg_d_r[SG_LJE_TAP][1], mag: lje_r};
      for (int k = 1; k < LJE_DLY; k++) lje_d_r[k] <= lje_d_r[k-1];
      ljd_d_r[0] <= '{neg: sg_d_r[SG_LJD_TAP][0], mag: ljd_r};
      for (int k = 1; k < LJD_DLY; k++) ljd_d_r[k] <= ljd_d_r[k-1];
    end
  end

  // final combine
  res_t fin_r, fin_nxt;

  always_comb begin
    side_t sd;
    bin_t  bn;
    mag_t  m;
    logic  lj_ok;
    sum_t  ec, cd, lje, ljd;
    sd = side_d_r[SIDE_DLY-1];
    bn = bin_d_r[BIN_DLY-1];
    m  = sd.tnz ? CAP_MAG : '0;
    lj_ok = sd.oo && (eps4_r != '0) && (sigma_sq_r != '0);
    fin_nxt.rdf_bin     = '0;
    fin_nxt.rdf_hit     = 1'b0;
    fin_nxt.range_error = 1'b0;
    if (sd.zero) begin
      // zero distance: every live term saturates
      ec  = sgn_mag(m, sd.qneg);
      cd  = sgn_mag(m, !sd.qneg);
      lje = lj_ok ? sgn_mag(CAP_MAG, 1'b0) : '0;
      ljd = lj_ok ? sgn_mag(CAP_MAG, 1'b1) : '0;
      fin_nxt.range_error = 1'b1;
    end else begin
      ec  = sgn_mag(em_d_r[EM_DLY-1], sd.qneg);
      cd  = sgn_mag(cd_r, !sd.qneg);
      lje = sd.oo ? sgn_mag(lje_d_r[LJE_DLY-1].mag, lje_d_r[LJE_DLY-1].neg) : '0;
      ljd = sd.oo ? sgn_mag(ljd_d_r[LJD_DLY-1].mag, ljd_d_r[LJD_DLY-1].neg) : '0;
      if (sd.oo) begin
        fin_nxt.rdf_bin     = bn.bin;
        fin_nxt.rdf_hit     = !bn.ge;
        fin_nxt.range_error = bn.ge;
      end
    end
    fin_nxt.force_over_r = sat48(ljd + cd);
    fin_nxt.energy_inc   = sat48(lje + ec);
    fin_nxt.coulomb_inc  = sat48(ec);
  end

  always_ff @(posedge clk) begin
    if (en) fin_r <= fin_nxt;
  end

  // output register with skid word
  res_t out_r, skid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= v_r[V_LEN-1];
      end
    end else if (v_r[V_LEN-1] && en) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      out_r <= skid_v_r ? skid_r : fin_r;
    end else if (en) begin
      skid_r <= fin_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(DATA_OUT_W - 3 * OUT_W - BIN_W){1'b0}}, out_r.rdf_bin,
                       out_r.coulomb_inc, out_r.energy_inc, out_r.force_over_r};
  assign out_tuser  = {out_r.range_error, out_r.rdf_hit};

endmodule

`default_nettype wire

// ----- rtl/spw_mul.sv -----
// ----------------------------------------------------------------------------
// spw_mul: pipelined 64 x 64 multiplier
// Four 32 x 32 partial products in the first stage, the full 128 bit
// product summed in the second stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spw_mul (
  input  logic                        clk,
  input  logic                        en,
  input  logic [spw_pkg::MUL_W-1:0]   a,
  input  logic [spw_pkg::MUL_W-1:0]   b,
  output logic [spw_pkg::PROD_W-1:0]  p
);
  import spw_pkg::*;

  logic [63:0]       p00_r, p01_r, p10_r, p11_r;
  logic [PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r <= 64'(a[31:0])  * 64'(b[31:0]);
      p01_r <= 64'(a[31:0])  * 64'(b[63:32]);
      p10_r <= 64'(a[63:32]) * 64'(b[31:0]);
      p11_r <= 64'(a[63:32]) * 64'(b[63:32]);
      p_r   <= {p11_r, p00_r} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0};
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

// ----- rtl/spw_isqrt.sv -----
// ----------------------------------------------------------------------------
// spw_isqrt: pipelined integer square root
// One result bit per stage, 28 stages for a 56 bit radicand.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spw_isqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [spw_pkg::SQ_IN_W-1:0]   v,
  output logic [spw_pkg::ROOT_W-1:0]    root
);
  import spw_pkg::*;

  typedef struct packed {
    logic [SQ_IN_W-1:0] rem;
    logic [SQ_IN_W-1:0] res;
  } sq_t;

  function automatic sq_t sq_step(input logic [SQ_IN_W-1:0] rin,
                                  input logic [SQ_IN_W-1:0] sin, input int k);
    logic [SQ_IN_W:0] bitv;
    logic [SQ_IN_W:0] trial;
    sq_t              o;
    bitv  = {{SQ_IN_W{1'b0}}, 1'b1} << (SQ_IN_W - 2 - 2 * k);
    trial = {1'b0, sin} + bitv;
    if ({1'b0, rin} >= trial) begin
      o.rem = rin - trial[SQ_IN_W-1:0];
      o.res = (sin >> 1) + bitv[SQ_IN_W-1:0];
    end else begin
      o.rem = rin;
      o.res = sin >> 1;
    end
    return o;
  endfunction

  sq_t st_r   [SQ_STAGES];
  sq_t st_nxt [SQ_STAGES];

  always_comb begin
    st_nxt[0] = sq_step(v, '0, 0);
    for (int k = 1; k < SQ_STAGES; k++) begin
      st_nxt[k] = sq_step(st_r[k-1].rem, st_r[k-1].res, k);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQ_STAGES; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign root = st_r[SQ_STAGES-1].res[ROOT_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/spw_div.sv -----
// ----------------------------------------------------------------------------
// spw_div: pipelined reciprocal divider
// Computes 2^56 / den by restoring division, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spw_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [spw_pkg::DEN_W-1:0]   den,
  output logic [spw_pkg::QUO_W-1:0]   quo
);
  import spw_pkg::*;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] q;
  } dv_t;

  function automatic dv_t dv_step(input dv_t s, input logic nbit);
    logic [DEN_W:0] sh;
    logic           ge;
    dv_t            o;
    sh    = {s.rem, nbit};
    ge    = sh >= {1'b0, s.den};
    o.den = s.den;
    o.rem = ge ? DEN_W'(sh - {1'b0, s.den}) : sh[DEN_W-1:0];
    o.q   = {s.q[QUO_W-2:0], ge};
    return o;
  endfunction

  dv_t st_r   [DIV_STAGES];
  dv_t st_nxt [DIV_STAGES];
  dv_t seed;

  always_comb begin
    seed.rem  = '0;
    seed.den  = den;
    seed.q    = '0;
    // numerator has only its top bit set
    st_nxt[0] = dv_step(seed, 1'b1);
    for (int j = 1; j < DIV_STAGES; j++) begin
      st_nxt[j] = dv_step(st_r[j-1], 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < DIV_STAGES; j++) begin
        st_r[j] <= st_nxt[j];
      end
    end
  end

  assign quo = st_r[DIV_STAGES-1].q;

endmodule

`default_nettype wire
